[hw/rtl/tsd_pkg.sv]
// tsd_pkg: shared types, constants and helpers for the tar stream deframer.
// Depends on nothing; used by tsd_front, tsd_queue, tsd_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

    localparam int RECORD_BYTES = 512;
    localparam int POS_W        = $clog2(RECORD_BYTES);

    localparam int NAME_LEN  = 100;
    localparam int SIZE_OFF  = 124;
    localparam int SIZE_LEN  = 12;
    localparam int MAGIC_OFF = 257;
    localparam int MAGIC_LEN = 5;

    localparam int SIZE_W   = 36;
    localparam int QUEUE_D  = 2;

    localparam logic [7:0] CHAR_SUBST = 8'h3F;   // '?'
    localparam logic [7:0] CHAR_ZERO  = 8'h30;   // '0'
    localparam logic [7:0] CHAR_SEVEN = 8'h37;   // '7'
    localparam logic [7:0] PRINT_LO   = 8'h20;
    localparam logic [7:0] PRINT_HI   = 8'h7E;

    localparam logic [2:0] KIND_NAME    = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_CONTENT = 3'd2;
    localparam logic [2:0] KIND_PAD     = 3'd3;
    localparam logic [2:0] KIND_IGNORED = 3'd4;

    localparam logic [1:0] STAT_NONE    = 2'd0;
    localparam logic [1:0] STAT_VALID   = 2'd1;
    localparam logic [1:0] STAT_END     = 2'd2;
    localparam logic [1:0] STAT_NOMAGIC = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_CONTENT,
        PH_PAD,
        PH_DONE
    } phase_t;

    // classified word passed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       name_pos;
        logic       size_pos;
        logic       magic_pos;
        logic       magic_ok;
    } item_t;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h75;  // u
            3'd1:    c = 8'h73;  // s
            3'd2:    c = 8'h74;  // t
            3'd3:    c = 8'h61;  // a
            3'd4:    c = 8'h72;  // r
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/tsd_front.sv]
// tsd_front: accepts archive words, tracks the offset within the record and
// tags each word with its header field. Depends on tsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [7:0]            in_data,
    input  logic                  q_ready,
    output logic                  in_ready,
    output logic                  push,
    output tsd_pkg::item_t        item
);

    logic [tsd_pkg::POS_W-1:0] pos_reg;
    logic [tsd_pkg::POS_W-1:0] pos_next;
    logic                      last;
    logic [2:0]                magic_idx;
    int                        pos_i;

    assign in_ready  = q_ready;
    assign push      = in_valid && q_ready;
    assign pos_i     = int'(pos_reg);
    assign last      = (pos_reg == tsd_pkg::POS_W'(tsd_pkg::RECORD_BYTES - 1));
    assign magic_idx = 3'(pos_i - tsd_pkg::MAGIC_OFF);

    always_comb
    begin
        item.data      = in_data;
        item.last      = last;
        item.name_pos  = (pos_i < tsd_pkg::NAME_LEN);
        item.size_pos  = (pos_i >= tsd_pkg::SIZE_OFF)
                         && (pos_i < tsd_pkg::SIZE_OFF + tsd_pkg::SIZE_LEN);
        item.magic_pos = (pos_i >= tsd_pkg::MAGIC_OFF)
                         && (pos_i < tsd_pkg::MAGIC_OFF + tsd_pkg::MAGIC_LEN);
        item.magic_ok  = (in_data == tsd_pkg::magic_char(magic_idx));
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            pos_next = last ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tsd_queue.sv]
// tsd_queue: two-entry queue of classified words between front and back.
// Depends on tsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tsd_pkg::item_t push_item,
    output logic           not_full,
    input  logic           pop_ready,
    output logic           not_empty,
    output tsd_pkg::item_t head
);

    tsd_pkg::item_t entry_reg [tsd_pkg::QUEUE_D];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           pop;

    assign not_full  = (count_reg != 2'(tsd_pkg::QUEUE_D));
    assign not_empty = (count_reg != 2'd0);
    assign pop       = not_empty && pop_ready;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tsd_back.sv]
// tsd_back: record phase machine, header checks, size parse and content count;
// drives the registered result word. Depends on tsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  tsd_pkg::item_t              q_item,
    output logic                        q_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  kind,
    output logic [7:0]                  out_byte,
    output logic                        record_end,
    output logic [1:0]                  header_status,
    output logic [tsd_pkg::SIZE_W-1:0]  file_size,
    output logic                        file_last
);

    tsd_pkg::phase_t             phase_reg;
    tsd_pkg::phase_t             phase_next;
    logic                        all_zero_reg;
    logic                        all_zero_next;
    logic                        magic_reg;
    logic                        magic_next;
    logic                        name_open_reg;
    logic                        name_open_next;
    logic [tsd_pkg::SIZE_W-1:0]  size_reg;
    logic [tsd_pkg::SIZE_W-1:0]  size_next;
    logic [tsd_pkg::SIZE_W-1:0]  left_reg;
    logic [tsd_pkg::SIZE_W-1:0]  left_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    logic [2:0]                  kind_reg;
    logic [2:0]                  kind_next;
    logic [7:0]                  byte_reg;
    logic [7:0]                  byte_next;
    logic                        rec_end_reg;
    logic [1:0]                  status_reg;
    logic [1:0]                  status_next;
    logic [tsd_pkg::SIZE_W-1:0]  fsize_reg;
    logic [tsd_pkg::SIZE_W-1:0]  fsize_next;
    logic                        flast_reg;
    logic                        flast_next;

    logic                        take;
    logic [7:0]                  b;
    logic                        zero_upd;
    logic                        magic_upd;
    logic [tsd_pkg::SIZE_W-1:0]  size_upd;
    logic                        is_digit;
    logic                        left_done;

    assign q_ready   = !out_valid_reg || out_ready;
    assign take      = q_valid && q_ready;
    assign b         = q_item.data;
    assign is_digit  = (b >= tsd_pkg::CHAR_ZERO) && (b <= tsd_pkg::CHAR_SEVEN);
    assign zero_upd  = all_zero_reg && (b == 8'h00);
    assign magic_upd = magic_reg && !(q_item.magic_pos && !q_item.magic_ok);
    assign size_upd  = (q_item.size_pos && is_digit)
                       ? {size_reg[tsd_pkg::SIZE_W-4:0], 3'b000}
                         + tsd_pkg::SIZE_W'(b[2:0])
                       : size_reg;
    assign left_done = (left_reg <= tsd_pkg::SIZE_W'(1));

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            unique case (phase_reg)
                tsd_pkg::PH_HEADER:
                begin
                    if (q_item.last)
                    begin
                        if (zero_upd || !magic_upd)
                            phase_next = tsd_pkg::PH_DONE;
                        else if (size_upd != '0)
                            phase_next = tsd_pkg::PH_CONTENT;
                        else
                            phase_next = tsd_pkg::PH_HEADER;
                    end
                end
                tsd_pkg::PH_CONTENT:
                begin
                    if (left_done)
                        phase_next = q_item.last ? tsd_pkg::PH_HEADER : tsd_pkg::PH_PAD;
                end
                tsd_pkg::PH_PAD:
                begin
                    if (q_item.last)
                        phase_next = tsd_pkg::PH_HEADER;
                end
                tsd_pkg::PH_DONE:
                begin
                    phase_next = tsd_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = tsd_pkg::PH_DONE;
                end
            endcase
        end
    end

    // result word and datapath
    always_comb
    begin
        all_zero_next  = all_zero_reg;
        magic_next     = magic_reg;
        name_open_next = name_open_reg;
        size_next      = size_reg;
        left_next      = left_reg;
        kind_next      = tsd_pkg::KIND_IGNORED;
        byte_next      = b;
        status_next    = tsd_pkg::STAT_NONE;
        fsize_next     = '0;
        flast_next     = 1'b0;
        unique case (phase_reg)
            tsd_pkg::PH_HEADER:
            begin
                kind_next     = tsd_pkg::KIND_HEADER;
                all_zero_next = zero_upd;
                magic_next    = magic_upd;
                size_next     = size_upd;
                if (q_item.name_pos && name_open_reg)
                begin
                    if (b == 8'h00)
                    begin
                        name_open_next = 1'b0;
                    end
                    else
                    begin
                        kind_next = tsd_pkg::KIND_NAME;
                        if (b < tsd_pkg::PRINT_LO || b > tsd_pkg::PRINT_HI)
                            byte_next = tsd_pkg::CHAR_SUBST;
                    end
                end
                if (q_item.last)
                begin
                    if (zero_upd)
                    begin
                        status_next = tsd_pkg::STAT_END;
                    end
                    else if (!magic_upd)
                    begin
                        status_next = tsd_pkg::STAT_NOMAGIC;
                    end
                    else
                    begin
                        status_next = tsd_pkg::STAT_VALID;
                        fsize_next  = size_upd;
                        left_next   = size_upd;
                    end
                    all_zero_next  = 1'b1;
                    magic_next     = 1'b1;
                    name_open_next = 1'b1;
                    size_next      = '0;
                end
            end
            tsd_pkg::PH_CONTENT:
            begin
                kind_next = tsd_pkg::KIND_CONTENT;
                if (left_done)
                begin
                    flast_next = 1'b1;
                    left_next  = '0;
                end
                else
                begin
                    left_next = left_reg - 1'b1;
                end
            end
            tsd_pkg::PH_PAD:
            begin
                kind_next = tsd_pkg::KIND_PAD;
            end
            tsd_pkg::PH_DONE:
            begin
                kind_next = tsd_pkg::KIND_IGNORED;
            end
            default:
            begin
                kind_next = tsd_pkg::KIND_IGNORED;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tsd_pkg::PH_HEADER;
            all_zero_reg  <= 1'b1;
            magic_reg     <= 1'b1;
            name_open_reg <= 1'b1;
            size_reg      <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                all_zero_reg  <= all_zero_next;
                magic_reg     <= magic_next;
                name_open_reg <= name_open_next;
                size_reg      <= size_next;
                left_reg      <= left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg    <= kind_next;
            byte_reg    <= byte_next;
            rec_end_reg <= q_item.last;
            status_reg  <= status_next;
            fsize_reg   <= fsize_next;
            flast_reg   <= flast_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign out_byte      = byte_reg;
    assign record_end    = rec_end_reg;
    assign header_status = status_reg;
    assign file_size     = fsize_reg;
    assign file_last     = flast_reg;

`ifndef SYNTHESIS
    a_status_on_record_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != tsd_pkg::STAT_NONE) |-> rec_end_reg)
        else $error("header status outside a record's last word");

    a_last_is_content: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && flast_reg |-> (kind_reg == tsd_pkg::KIND_CONTENT))
        else $error("file_last on a non-content word");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tsd_pkg::PH_DONE) |=> (phase_reg == tsd_pkg::PH_DONE))
        else $error("left the done phase without reset");

    a_content_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tsd_pkg::PH_CONTENT) |-> (left_reg != '0))
        else $error("content phase with nothing left");
`endif

endmodule

`default_nettype wire

[hw/rtl/tar_stream_deframer_unit.sv]
// tar_stream_deframer_unit: top level; front classifier, two-word queue and
// back phase machine. Depends on tsd_pkg, tsd_front, tsd_queue, tsd_back.
// Throughput: one word per cycle sustained, in and out, while m_tready is held high.
// An accepted input word is written into the queue, then taken into the registered result word on m_*.
// Reset (rst_n low, asynchronous): expects a header record at offset 0,
// queue and result register empty.
`timescale 1ns / 1ps
`default_nettype none

module tar_stream_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] out_byte, [43:8] file_size, [44] file_last
    output logic [4:0]  m_tuser,   // [2:0] kind, [4:3] header_status
    output logic        m_tlast    // record_end
);

    tsd_pkg::item_t              fe_item;
    tsd_pkg::item_t              q_head;
    logic                        fe_push;
    logic                        q_not_full;
    logic                        q_not_empty;
    logic                        be_ready;
    logic [2:0]                  kind;
    logic [7:0]                  out_byte;
    logic [1:0]                  header_status;
    logic [tsd_pkg::SIZE_W-1:0]  file_size;
    logic                        file_last;

    tsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .q_ready  (q_not_full),
        .in_ready (s_tready),
        .push     (fe_push),
        .item     (fe_item)
    );

    tsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fe_push),
        .push_item (fe_item),
        .not_full  (q_not_full),
        .pop_ready (be_ready),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    tsd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_not_empty),
        .q_item        (q_head),
        .q_ready       (be_ready),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .kind          (kind),
        .out_byte      (out_byte),
        .record_end    (m_tlast),
        .header_status (header_status),
        .file_size     (file_size),
        .file_last     (file_last)
    );

    assign m_tdata = {3'b000, file_last, file_size, out_byte};
    assign m_tuser = {header_status, kind};

endmodule

`default_nettype wire

[tb/tb.sv]
// tb: self-checking bench for tar_stream_deframer_unit. Streams whole tar records
// through s_*, predicts every classified word and checks the m_* side against it.
// Depends on tsd_pkg and the deframer RTL only.
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT  = 5000;
    localparam int LONG_HOLD   = 600;
    localparam int RAND_BYTES  = 1700;
    localparam int TAIL_EXTRA  = 150;
    localparam int FILE_BUDGET = RAND_BYTES - tsd_pkg::RECORD_BYTES - TAIL_EXTRA;
    localparam logic [39:0] USTAR = "ustar";

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic        rec_end;
        logic [1:0]  status;
        logic [35:0] fsize;
        logic        flast;
    } deframed_t;

    typedef enum int {
        TAIL_ZERO_RECORD,
        TAIL_NO_MAGIC,
        TAIL_HUGE_FILE
    } tail_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    logic [7:0] archive_q[$];
    deframed_t  expected_q[$];
    logic [7:0] hdr_buf [tsd_pkg::RECORD_BYTES];

    // deframer state as predicted
    int unsigned      rec_pos = 0;
    tsd_pkg::phase_t  ph = tsd_pkg::PH_HEADER;
    bit               all_zero = 1'b1;
    bit               magic_ok = 1'b1;
    bit               name_open = 1'b1;
    logic [35:0]      size_acc = '0;
    logic [35:0]      bytes_left = '0;

    int err_cnt = 0;
    int got_cnt = 0;
    int tx_wait = 0;
    int rx_wait = 0;
    int stall_cycles = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    bit rx_held = 1'b0;

    tar_stream_deframer_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic deframe_byte(input logic [7:0] b, output deframed_t w);
        int unsigned p;
        bit at_end;
        begin
            p = rec_pos;
            at_end = (p == tsd_pkg::RECORD_BYTES - 1);
            w = '0;
            w.kind = tsd_pkg::KIND_IGNORED;
            w.data = b;
            w.rec_end = at_end;
            case (ph)
                tsd_pkg::PH_HEADER:
                begin
                    w.kind = tsd_pkg::KIND_HEADER;
                    if (b != 8'h00)
                        all_zero = 1'b0;
                    if (p < tsd_pkg::NAME_LEN && name_open)
                    begin
                        if (b == 8'h00)
                            name_open = 1'b0;
                        else
                        begin
                            w.kind = tsd_pkg::KIND_NAME;
                            if (b < tsd_pkg::PRINT_LO || b > tsd_pkg::PRINT_HI)
                                w.data = tsd_pkg::CHAR_SUBST;
                        end
                    end
                    if (p >= tsd_pkg::SIZE_OFF && p < tsd_pkg::SIZE_OFF + tsd_pkg::SIZE_LEN
                        && b >= tsd_pkg::CHAR_ZERO && b <= tsd_pkg::CHAR_SEVEN)
                        size_acc = (size_acc << 3) + 36'(b - tsd_pkg::CHAR_ZERO);
                    if (p >= tsd_pkg::MAGIC_OFF && p < tsd_pkg::MAGIC_OFF + tsd_pkg::MAGIC_LEN
                        && b != USTAR[39 - 8 * (p - tsd_pkg::MAGIC_OFF) -: 8])
                        magic_ok = 1'b0;
                    if (at_end)
                    begin
                        if (all_zero)
                        begin
                            w.status = tsd_pkg::STAT_END;
                            ph = tsd_pkg::PH_DONE;
                        end
                        else if (!magic_ok)
                        begin
                            w.status = tsd_pkg::STAT_NOMAGIC;
                            ph = tsd_pkg::PH_DONE;
                        end
                        else
                        begin
                            w.status = tsd_pkg::STAT_VALID;
                            w.fsize = size_acc;
                            bytes_left = size_acc;
                            ph = (size_acc != 0) ? tsd_pkg::PH_CONTENT : tsd_pkg::PH_HEADER;
                        end
                        all_zero = 1'b1;
                        magic_ok = 1'b1;
                        name_open = 1'b1;
                        size_acc = '0;
                    end
                end
                tsd_pkg::PH_CONTENT:
                begin
                    w.kind = tsd_pkg::KIND_CONTENT;
                    if (bytes_left <= 1)
                    begin
                        w.flast = 1'b1;
                        bytes_left = '0;
                        ph = at_end ? tsd_pkg::PH_HEADER : tsd_pkg::PH_PAD;
                    end
                    else
                        bytes_left = bytes_left - 1;
                end
                tsd_pkg::PH_PAD:
                begin
                    w.kind = tsd_pkg::KIND_PAD;
                    if (at_end)
                        ph = tsd_pkg::PH_HEADER;
                end
                default: ;
            endcase
            rec_pos = at_end ? 0 : p + 1;
        end
    endtask

    // size digits either zero-padded or scattered among non-octal filler
    task automatic build_header(input int name_len, input logic [35:0] size,
                                input bit good_magic, input bit spread);
        int i;
        int n;
        int digits_left;
        int bad;
        logic [7:0] f;
        begin
            for (i = 0; i < tsd_pkg::RECORD_BYTES; i++)
                hdr_buf[i] = 8'($urandom);
            for (i = 0; i < name_len; i++)
                hdr_buf[i] = 8'($urandom_range(1, 255));
            if (name_len < tsd_pkg::NAME_LEN)
                hdr_buf[name_len] = 8'h00;
            n = 0;
            while (n < tsd_pkg::SIZE_LEN && (size >> (3 * n)) != 0)
                n++;
            digits_left = n;
            for (i = 0; i < tsd_pkg::SIZE_LEN; i++)
            begin
                if (digits_left > 0 && (digits_left == tsd_pkg::SIZE_LEN - i
                    || (spread && $urandom_range(0, 1) == 1)))
                begin
                    digits_left--;
                    hdr_buf[tsd_pkg::SIZE_OFF + i] =
                        tsd_pkg::CHAR_ZERO + 8'((size >> (3 * digits_left)) & 36'h7);
                end
                else if (spread)
                begin
                    do
                        f = 8'($urandom);
                    while (f >= tsd_pkg::CHAR_ZERO && f <= tsd_pkg::CHAR_SEVEN);
                    hdr_buf[tsd_pkg::SIZE_OFF + i] = f;
                end
                else
                    hdr_buf[tsd_pkg::SIZE_OFF + i] = tsd_pkg::CHAR_ZERO;
            end
            for (i = 0; i < tsd_pkg::MAGIC_LEN; i++)
                hdr_buf[tsd_pkg::MAGIC_OFF + i] = USTAR[39 - 8 * i -: 8];
            if (!good_magic)
            begin
                bad = tsd_pkg::MAGIC_OFF + $urandom_range(0, tsd_pkg::MAGIC_LEN - 1);
                hdr_buf[bad] = hdr_buf[bad] ^ 8'($urandom_range(1, 255));
            end
        end
    endtask

    task automatic push_record();
        int i;
        begin
            for (i = 0; i < tsd_pkg::RECORD_BYTES; i++)
                archive_q.push_back(hdr_buf[i]);
        end
    endtask

    task automatic push_random(input int count);
        int i;
        begin
            for (i = 0; i < count; i++)
                archive_q.push_back(8'($urandom));
        end
    endtask

    // content then padding up to the record boundary
    task automatic push_body(input int size);
        begin
            push_random(size);
            push_random((tsd_pkg::RECORD_BYTES - size % tsd_pkg::RECORD_BYTES)
                        % tsd_pkg::RECORD_BYTES);
        end
    endtask

    initial
    begin
        int files;
        int fsz;
        int flen;
        bit fits;
        tail_t tail;

        files = 0;
        fits = 1'b1;
        while (fits)
        begin
            case ($urandom_range(0, 9))
                0, 1:    fsz = 0;
                2:       fsz = tsd_pkg::RECORD_BYTES;
                3:       fsz = tsd_pkg::RECORD_BYTES - 1 + 2 * $urandom_range(0, 1);
                default: fsz = $urandom_range(1, 300);
            endcase
            flen = tsd_pkg::RECORD_BYTES
                   + (fsz + tsd_pkg::RECORD_BYTES - 1) / tsd_pkg::RECORD_BYTES
                     * tsd_pkg::RECORD_BYTES;
            if (files != 0 && archive_q.size() + flen > FILE_BUDGET)
                fits = 1'b0;
            else
            begin
                if (files == 0)
                begin
                    build_header(tsd_pkg::NAME_LEN, 36'(fsz), 1'b1, 1'b1);
                    hdr_buf[0] = 8'h01; hdr_buf[1] = 8'h1F; hdr_buf[2] = 8'h20;
                    hdr_buf[3] = 8'h7E; hdr_buf[4] = 8'h7F; hdr_buf[5] = 8'h80;
                    hdr_buf[6] = 8'hFF;
                end
                else
                    build_header($urandom_range(0, tsd_pkg::NAME_LEN), 36'(fsz), 1'b1,
                                 1'($urandom));
                push_record();
                push_body(fsz);
                files++;
            end
        end

        tail = tail_t'($urandom_range(0, 2));
        case (tail)
            TAIL_ZERO_RECORD:
            begin
                foreach (hdr_buf[i])
                    hdr_buf[i] = 8'h00;
                push_record();
                push_random(TAIL_EXTRA);
            end
            TAIL_NO_MAGIC:
            begin
                build_header($urandom_range(1, tsd_pkg::NAME_LEN),
                             36'($urandom_range(0, 4000)), 1'b0, 1'($urandom));
                push_record();
                push_random(TAIL_EXTRA);
            end
            default:
            begin
                build_header(20, 36'hFFFFFFFFF, 1'b1, 1'b0);
                push_record();
                push_random(TAIL_EXTRA);
            end
        endcase

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (archive_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_cnt == 0 && expected_q.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // driver
    always @(posedge clk)
    begin
        deframed_t w;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                deframe_byte(s_tdata, w);
                expected_q.push_back(w);
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_wait != 0)
                begin
                    tx_wait <= tx_wait - 1;
                    s_tvalid <= 1'b0;
                end
                else if (archive_q.size() != 0)
                begin
                    s_tdata <= archive_q.pop_front();
                    s_tvalid <= 1'b1;
                    tx_wait <= tx_burst ? 0 : $urandom_range(0, 13);
                    if ($urandom_range(0, 199) == 0)
                        tx_burst <= !tx_burst;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver back-pressure
    always @(posedge clk)
    begin
        deframed_t want;
        int g;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected word: tdata %h tuser %h", m_tdata, m_tuser);
                    err_cnt++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tuser[2:0] !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser[2:0]);
                        err_cnt++;
                    end
                    if (m_tdata[7:0] !== want.data)
                    begin
                        $error("out_byte: expected %h, got %h", want.data, m_tdata[7:0]);
                        err_cnt++;
                    end
                    if (m_tlast !== want.rec_end)
                    begin
                        $error("record_end: expected %0d, got %0d", want.rec_end, m_tlast);
                        err_cnt++;
                    end
                    if (m_tuser[4:3] !== want.status)
                    begin
                        $error("header_status: expected %0d, got %0d", want.status,
                               m_tuser[4:3]);
                        err_cnt++;
                    end
                    if (m_tdata[43:8] !== want.fsize)
                    begin
                        $error("file_size: expected %0d, got %0d", want.fsize, m_tdata[43:8]);
                        err_cnt++;
                    end
                    if (m_tdata[44] !== want.flast)
                    begin
                        $error("file_last: expected %0d, got %0d", want.flast, m_tdata[44]);
                        err_cnt++;
                    end
                end
                got_cnt++;
            end

            if (rx_wait != 0)
            begin
                rx_wait <= rx_wait - 1;
                m_tready <= (rx_wait == 1);
            end
            else if (m_tvalid && m_tready)
            begin
                if (!rx_held && got_cnt == 400)
                begin
                    rx_held <= 1'b1;
                    g = LONG_HOLD;
                end
                else
                    g = rx_burst ? 0 : $urandom_range(0, 13);
                if ($urandom_range(0, 199) == 0)
                    rx_burst <= !rx_burst;
                rx_wait <= g;
                m_tready <= (g == 0);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog: no word moving on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == IDLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule
